FILE: hw/rtl/owb_pkg.sv
package owb_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_W         = $clog2(BITS_PER_BYTE);
    localparam int TICK_W        = 10;
    localparam int QUEUE_DEPTH   = 2;

    // configuration register indexes
    localparam int CFG_COUNT = 7;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_RECOV    = 3'd6;

    localparam logic [TICK_W-1:0] CFG_RESET_VAL [CFG_COUNT] = '{
        10'd490, 10'd100, 10'd480, 10'd2, 10'd45, 10'd4, 10'd65
    };

    // request kind codes as they arrive on the bus
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] write_byte;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [TICK_W-1:0]    data;
    } t_cfg_wr;

    // result layout, last field in the lowest bits
    typedef struct packed {
        logic [3:0] pad;
        logic [7:0] read_data;
        logic       presence;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } t_result;

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_RST_LEAD  = 10'b00_0000_0010,
        PH_RST_LOW   = 10'b00_0000_0100,
        PH_RST_WAIT  = 10'b00_0000_1000,
        PH_RST_RECOV = 10'b00_0001_0000,
        PH_WR_START  = 10'b00_0010_0000,
        PH_WR_HOLD   = 10'b00_0100_0000,
        PH_RD_START  = 10'b00_1000_0000,
        PH_RD_WAIT   = 10'b01_0000_0000,
        PH_RD_RECOV  = 10'b10_0000_0000
    } t_phase;

endpackage

FILE: hw/rtl/owb_front.sv
module owb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_write_byte,
    input  logic              i_line_level,
    output logic              o_valid,
    input  logic              i_ready,
    output owb_pkg::t_item    o_item
);

    logic           r_valid;
    owb_pkg::t_item r_item;
    owb_pkg::t_item n_item;

    // decode the request kind
    always_comb begin
        n_item.write_byte = i_write_byte;
        n_item.line_level = i_line_level;
        case (i_kind)
            owb_pkg::KIND_TICK:  n_item.op = owb_pkg::OP_TICK;
            owb_pkg::KIND_RESET: n_item.op = owb_pkg::OP_RESET;
            owb_pkg::KIND_WRITE: n_item.op = owb_pkg::OP_WRITE;
            owb_pkg::KIND_READ:  n_item.op = owb_pkg::OP_READ;
            default:             n_item.op = owb_pkg::OP_TICK;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: hw/rtl/owb_queue.sv
module owb_queue #(
    parameter int DEPTH = owb_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  owb_pkg::t_item    i_push_item,
    output logic              o_pop_valid,
    input  logic              i_pop,
    output owb_pkg::t_item    o_pop_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    owb_pkg::t_item  r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: hw/rtl/owb_back.sv
module owb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  owb_pkg::t_cfg_wr  i_cfg,
    input  logic              i_valid,
    output logic              o_pop,
    input  owb_pkg::t_item    i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output owb_pkg::t_result  o_result
);

    logic [owb_pkg::TICK_W-1:0] r_cfg [owb_pkg::CFG_COUNT];

    owb_pkg::t_phase             r_phase, n_phase;
    logic [owb_pkg::TICK_W-1:0]  r_cnt, n_cnt;
    logic [owb_pkg::BIT_W-1:0]   r_bit, n_bit;
    logic [7:0]                  r_shift, n_shift;
    logic                        r_pres, n_pres;
    logic [7:0]                  r_read, n_read;
    logic                        r_out_valid;
    owb_pkg::t_result            r_out, n_out;

    logic [owb_pkg::TICK_W-1:0]  cnt_inc;
    logic [owb_pkg::TICK_W-1:0]  len;
    logic                        last_bit;
    logic                        done;
    logic                        out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_valid && out_free;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < owb_pkg::CFG_COUNT; i++) begin
                r_cfg[i] <= owb_pkg::CFG_RESET_VAL[i];
            end
        end else if (i_cfg.we && i_cfg.idx < owb_pkg::CFG_IDX_W'(owb_pkg::CFG_COUNT)) begin
            r_cfg[i_cfg.idx] <= i_cfg.data;
        end
    end

    // duration of the running phase
    always_comb begin
        case (r_phase)
            owb_pkg::PH_RST_LEAD:  len = r_cfg[owb_pkg::CFG_SLOT_START];
            owb_pkg::PH_RST_LOW:   len = r_cfg[owb_pkg::CFG_RESET_LOW];
            owb_pkg::PH_RST_WAIT:  len = r_cfg[owb_pkg::CFG_PRESENCE_WAIT];
            owb_pkg::PH_RST_RECOV: len = r_cfg[owb_pkg::CFG_RESET_RECOV];
            owb_pkg::PH_WR_START:  len = r_cfg[owb_pkg::CFG_SLOT_START];
            owb_pkg::PH_WR_HOLD:   len = r_cfg[owb_pkg::CFG_WRITE_HOLD];
            owb_pkg::PH_RD_START:  len = r_cfg[owb_pkg::CFG_SLOT_START];
            owb_pkg::PH_RD_WAIT:   len = r_cfg[owb_pkg::CFG_READ_SAMPLE];
            owb_pkg::PH_RD_RECOV:  len = r_cfg[owb_pkg::CFG_READ_RECOV];
            default:               len = owb_pkg::TICK_W'(1);
        endcase
    end

    assign cnt_inc  = r_cnt + 1'b1;
    assign last_bit = (r_bit == owb_pkg::BIT_W'(owb_pkg::BITS_PER_BYTE - 1));

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_pres  = r_pres;
        n_read  = r_read;
        done    = 1'b0;
        if (i_item.op == owb_pkg::OP_TICK) begin
            if (r_phase != owb_pkg::PH_IDLE) begin
                if (cnt_inc >= len) begin
                    n_cnt = '0;
                    case (r_phase)
                        owb_pkg::PH_RST_LEAD:  n_phase = owb_pkg::PH_RST_LOW;
                        owb_pkg::PH_RST_LOW:   n_phase = owb_pkg::PH_RST_WAIT;
                        owb_pkg::PH_RST_WAIT: begin
                            n_pres  = !i_item.line_level;
                            n_phase = owb_pkg::PH_RST_RECOV;
                        end
                        owb_pkg::PH_RST_RECOV: begin
                            n_phase = owb_pkg::PH_IDLE;
                            done    = 1'b1;
                        end
                        owb_pkg::PH_WR_START:  n_phase = owb_pkg::PH_WR_HOLD;
                        owb_pkg::PH_WR_HOLD: begin
                            n_shift = {1'b0, r_shift[7:1]};
                            if (last_bit) begin
                                n_bit   = '0;
                                n_phase = owb_pkg::PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_bit   = r_bit + 1'b1;
                                n_phase = owb_pkg::PH_WR_START;
                            end
                        end
                        owb_pkg::PH_RD_START:  n_phase = owb_pkg::PH_RD_WAIT;
                        owb_pkg::PH_RD_WAIT: begin
                            n_shift = {i_item.line_level, r_shift[7:1]};
                            n_phase = owb_pkg::PH_RD_RECOV;
                        end
                        owb_pkg::PH_RD_RECOV: begin
                            if (last_bit) begin
                                n_read  = r_shift;
                                n_bit   = '0;
                                n_phase = owb_pkg::PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_bit   = r_bit + 1'b1;
                                n_phase = owb_pkg::PH_RD_START;
                            end
                        end
                        default:               n_phase = owb_pkg::PH_IDLE;
                    endcase
                end else begin
                    n_cnt = cnt_inc;
                end
            end
        end else if (r_phase == owb_pkg::PH_IDLE) begin
            // commands only start from idle, otherwise dropped
            n_bit = '0;
            n_cnt = '0;
            case (i_item.op)
                owb_pkg::OP_RESET: n_phase = owb_pkg::PH_RST_LEAD;
                owb_pkg::OP_WRITE: begin
                    n_shift = i_item.write_byte;
                    n_phase = owb_pkg::PH_WR_START;
                end
                default: begin
                    n_shift = '0;
                    n_phase = owb_pkg::PH_RD_START;
                end
            endcase
        end
    end

    // result reflects the state after this request
    always_comb begin
        n_out           = '0;
        n_out.read_data = n_read;
        n_out.presence  = n_pres;
        n_out.done_res  = done;
        n_out.busy_res  = (n_phase != owb_pkg::PH_IDLE);
        case (n_phase)
            owb_pkg::PH_RST_LOW,
            owb_pkg::PH_WR_START,
            owb_pkg::PH_RD_START: n_out.drive_low = 1'b1;
            owb_pkg::PH_WR_HOLD:  n_out.drive_low = !n_shift[0];
            default:              n_out.drive_low = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= owb_pkg::PH_IDLE;
            r_cnt       <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_pres      <= 1'b0;
            r_read      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_pres  <= n_pres;
                r_read  <= n_read;
            end
            if (out_free) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.drive_low |-> r_out.busy_res)
        else $error("line driven while not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res)
        else $error("done reported while still busy");

    a_bit_in_byte_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit != '0 |-> (r_phase == owb_pkg::PH_WR_START || r_phase == owb_pkg::PH_WR_HOLD
            || r_phase == owb_pkg::PH_RD_START || r_phase == owb_pkg::PH_RD_WAIT
            || r_phase == owb_pkg::PH_RD_RECOV))
        else $error("bit index set outside a byte operation");

    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_pop) && r_phase == owb_pkg::PH_IDLE |-> r_cnt == '0)
        else $error("tick counter left running in idle");

endmodule

FILE: hw/rtl/one_wire_bus_master.sv
// single-wire bus master. each request on the slave side is either a
// one-microsecond tick or a command (reset, write byte, read byte); commands
// that arrive while an operation runs are dropped and take no bus time. every
// request yields exactly one result on the master side showing the line drive,
// busy, done, the last presence answer and the last byte read, as they stand
// after that request. slot timing is set by the seven 10-bit duration
// registers, written through the plain write port; the user must write them
// only while idle, which the block itself does not enforce (index 0 reset low,
// 1 presence wait, 2 reset recovery, 3 slot start, 4 write hold, 5 read sample,
// 6 read recovery; index 7 is ignored; a zero acts as one). throughput is one
// request per clock when the master side does not stall; a request passes a
// decode register, a two-entry queue and the phase engine with its result
// register, in that order. the engine holds one phase counter and a single
// compare.
module one_wire_bus_master #(
    parameter int QUEUE_DEPTH = owb_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // write_byte[7:0], line_level[8]
    input  logic [1:0]                     s_axis_tuser,  // kind[1:0]
    // master side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,  // drive_low[0], busy_res[1],
                                                          // done_res[2], presence[3],
                                                          // read_data[11:4]
    // configuration
    input  logic                           i_cfg_we,
    input  logic [owb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [owb_pkg::TICK_W-1:0]     i_cfg_data
);

    logic              front_valid;
    logic              front_ready;
    owb_pkg::t_item    front_item;
    logic              q_valid;
    logic              q_pop;
    owb_pkg::t_item    q_item;
    owb_pkg::t_cfg_wr  cfg_wr;
    owb_pkg::t_result  result;

    assign cfg_wr.we   = i_cfg_we;
    assign cfg_wr.idx  = i_cfg_idx;
    assign cfg_wr.data = i_cfg_data;

    // decode request kind and capture payload
    owb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_write_byte (s_axis_tdata[7:0]),
        .i_line_level (s_axis_tdata[8]),
        .o_valid      (front_valid),
        .i_ready      (front_ready),
        .o_item       (front_item)
    );

    // short queue so decode and engine stall independently
    owb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_item   (q_item)
    );

    // phase engine with result register
    owb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_valid  (q_valid),
        .o_pop    (q_pop),
        .i_item   (q_item),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = result;

endmodule
